// File: rtl/tgp_pkg.sv
// shared types and codes for the turtle grid plotter
`timescale 1ns / 1ps

package tgp_pkg;

  // command codes
  localparam logic [2:0] OP_PEN_UP     = 3'd0;
  localparam logic [2:0] OP_PEN_DOWN   = 3'd1;
  localparam logic [2:0] OP_TURN_RIGHT = 3'd2;
  localparam logic [2:0] OP_TURN_LEFT  = 3'd3;
  localparam logic [2:0] OP_FORWARD    = 3'd4;
  localparam logic [2:0] OP_READ_ROW   = 3'd5;

  // heading codes
  localparam logic [1:0] HEAD_EAST  = 2'd0;
  localparam logic [1:0] HEAD_SOUTH = 2'd1;
  localparam logic [1:0] HEAD_WEST  = 2'd2;
  localparam logic [1:0] HEAD_NORTH = 2'd3;

  typedef struct packed {
    logic [2:0] op;
    logic [5:0] distance;
    logic [4:0] row_select;
  } in_item_t;

  typedef struct packed {
    logic [4:0]  row_pos;
    logic [4:0]  col_pos;
    logic [1:0]  heading;
    logic        pen_down;
    logic [31:0] row_bits;
  } out_item_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_STEP,
    S_READ,
    S_DONE
  } state_t;

  // controller to datapath
  typedef struct packed {
    logic accept;
    logic step;
    logic cap_row;
    logic load_out;
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic last_step;
    logic out_free;
  } status_t;

endpackage

// File: rtl/tgp_ram.sv
// generic simple dual port ram with registered read
`timescale 1ns / 1ps

module tgp_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

// File: rtl/tgp_ctrl.sv
// command sequencer for the turtle grid plotter
`timescale 1ns / 1ps

module tgp_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  input  tgp_pkg::in_item_t in_data,
  output logic              in_stall,
  input  tgp_pkg::status_t  status,
  output tgp_pkg::cmd_t     cmd
);

  tgp_pkg::state_t state_r, state_nxt;
  logic            accept;

  assign in_stall = (state_r != tgp_pkg::S_IDLE);
  assign accept   = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= tgp_pkg::S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      tgp_pkg::S_IDLE: begin
        if (accept) begin
          if (in_data.op == tgp_pkg::OP_FORWARD && in_data.distance != 6'd0) begin
            state_nxt = tgp_pkg::S_STEP;
          end else if (in_data.op == tgp_pkg::OP_READ_ROW) begin
            state_nxt = tgp_pkg::S_READ;
          end else begin
            state_nxt = tgp_pkg::S_DONE;
          end
        end
      end
      tgp_pkg::S_STEP: begin
        if (status.last_step) begin
          state_nxt = tgp_pkg::S_DONE;
        end
      end
      tgp_pkg::S_READ: begin
        state_nxt = tgp_pkg::S_DONE;
      end
      tgp_pkg::S_DONE: begin
        if (status.out_free) begin
          state_nxt = tgp_pkg::S_IDLE;
        end
      end
      default: begin
        state_nxt = tgp_pkg::S_IDLE;
      end
    endcase
  end

  // commands
  always_comb begin
    cmd = '0;
    case (state_r)
      tgp_pkg::S_IDLE: cmd.accept   = accept;
      tgp_pkg::S_STEP: cmd.step     = 1'b1;
      tgp_pkg::S_READ: cmd.cap_row  = 1'b1;
      tgp_pkg::S_DONE: cmd.load_out = status.out_free;
      default:         cmd          = '0;
    endcase
  end

endmodule

// File: rtl/tgp_datapath.sv
// turtle position, heading, pen, grid store and result register
`timescale 1ns / 1ps

module tgp_datapath #(
  parameter int GRID_SIZE = 32
) (
  input  logic               clk,
  input  logic               rst_n,
  input  tgp_pkg::in_item_t  in_data,
  input  tgp_pkg::cmd_t      cmd,
  output tgp_pkg::status_t   status,
  output logic               out_valid,
  input  logic               out_stall,
  output tgp_pkg::out_item_t out_data
);

  localparam int POS_W = $clog2(GRID_SIZE);

  logic [POS_W-1:0]     row_r, row_nxt, col_r, col_nxt;
  logic [1:0]           dir_r, dir_nxt;
  logic                 pen_r, pen_nxt;
  logic [5:0]           cnt_r, cnt_nxt;
  logic                 sel_ok_r, sel_ok_nxt;
  logic [31:0]          bits_r, bits_nxt;
  logic                 wp_r, wp_nxt;
  logic [POS_W-1:0]     wrow_r, wrow_nxt, wcol_r, wcol_nxt;
  logic                 fwd_r, fwd_nxt;
  logic [GRID_SIZE-1:0] fwd_data_r;
  logic                 rvld_r;
  logic [GRID_SIZE-1:0] valid_r, valid_nxt;
  logic                 out_valid_r, out_valid_nxt;
  tgp_pkg::out_item_t   out_data_r;

  logic [POS_W:0]       row_inc, col_inc;
  logic [POS_W-1:0]     step_row, step_col;
  logic [POS_W+4:0]     sel_ext, row_ext, col_ext;
  logic [POS_W-1:0]     sel_idx, raddr;
  logic [GRID_SIZE-1:0] rdata, base, wdata, rd_masked;
  logic [GRID_SIZE+31:0] bits_ext;

  assign row_inc = (POS_W+1)'(row_r) + (POS_W+1)'(1);
  assign col_inc = (POS_W+1)'(col_r) + (POS_W+1)'(1);

  // one cell toward the heading, held at the edge
  always_comb begin
    step_row = row_r;
    step_col = col_r;
    case (dir_r)
      tgp_pkg::HEAD_EAST: begin
        if (col_inc < (POS_W+1)'(GRID_SIZE)) step_col = col_inc[POS_W-1:0];
      end
      tgp_pkg::HEAD_SOUTH: begin
        if (row_inc < (POS_W+1)'(GRID_SIZE)) step_row = row_inc[POS_W-1:0];
      end
      tgp_pkg::HEAD_WEST: begin
        if (col_r != '0) step_col = col_r - POS_W'(1);
      end
      tgp_pkg::HEAD_NORTH: begin
        if (row_r != '0) step_row = row_r - POS_W'(1);
      end
      default: begin
        step_row = row_r;
      end
    endcase
  end

  assign sel_ext = (POS_W+5)'(in_data.row_select);
  assign sel_idx = sel_ext[POS_W-1:0];
  assign raddr   = cmd.step ? step_row : sel_idx;

  // rows never written read as zero
  assign rd_masked = rvld_r ? rdata : '0;
  assign base      = fwd_r ? fwd_data_r : rd_masked;
  assign wdata     = base | (GRID_SIZE'(1) << wcol_r);
  assign bits_ext  = (GRID_SIZE+32)'(rd_masked);

  tgp_ram #(
    .WIDTH (GRID_SIZE),
    .DEPTH (GRID_SIZE)
  ) u_grid (
    .clk   (clk),
    .we    (wp_r),
    .waddr (wrow_r),
    .wdata (wdata),
    .raddr (raddr),
    .rdata (rdata)
  );

  always_comb begin
    row_nxt    = row_r;
    col_nxt    = col_r;
    dir_nxt    = dir_r;
    pen_nxt    = pen_r;
    cnt_nxt    = cnt_r;
    sel_ok_nxt = sel_ok_r;
    bits_nxt   = bits_r;
    wp_nxt     = 1'b0;
    wrow_nxt   = wrow_r;
    wcol_nxt   = wcol_r;
    fwd_nxt    = 1'b0;
    valid_nxt  = valid_r;
    if (wp_r) begin
      valid_nxt[wrow_r] = 1'b1;
    end
    if (cmd.accept) begin
      cnt_nxt    = in_data.distance;
      sel_ok_nxt = 7'(in_data.row_select) < 7'(GRID_SIZE);
      bits_nxt   = '0;
      case (in_data.op)
        tgp_pkg::OP_PEN_UP:     pen_nxt = 1'b0;
        tgp_pkg::OP_PEN_DOWN:   pen_nxt = 1'b1;
        tgp_pkg::OP_TURN_RIGHT: dir_nxt = dir_r + 2'd1;
        tgp_pkg::OP_TURN_LEFT:  dir_nxt = dir_r + 2'd3;
        default:                dir_nxt = dir_r;
      endcase
    end
    if (cmd.step) begin
      row_nxt  = step_row;
      col_nxt  = step_col;
      cnt_nxt  = cnt_r - 6'd1;
      wp_nxt   = pen_r;
      wrow_nxt = step_row;
      wcol_nxt = step_col;
      // same row being written right now: the read returns stale data
      fwd_nxt  = wp_r && (wrow_r == step_row);
    end
    if (cmd.cap_row) begin
      bits_nxt = sel_ok_r ? bits_ext[31:0] : '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_r    <= '0;
      col_r    <= '0;
      dir_r    <= tgp_pkg::HEAD_EAST;
      pen_r    <= 1'b0;
      cnt_r    <= '0;
      wp_r     <= 1'b0;
      fwd_r    <= 1'b0;
      valid_r  <= '0;
    end else begin
      row_r    <= row_nxt;
      col_r    <= col_nxt;
      dir_r    <= dir_nxt;
      pen_r    <= pen_nxt;
      cnt_r    <= cnt_nxt;
      wp_r     <= wp_nxt;
      fwd_r    <= fwd_nxt;
      valid_r  <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    sel_ok_r   <= sel_ok_nxt;
    bits_r     <= bits_nxt;
    wrow_r     <= wrow_nxt;
    wcol_r     <= wcol_nxt;
    fwd_data_r <= wdata;
    rvld_r     <= valid_r[raddr];
  end

  // result register
  assign status.out_free  = !out_valid_r || !out_stall;
  assign status.last_step = (cnt_r == 6'd1);

  assign row_ext = (POS_W+5)'(row_r);
  assign col_ext = (POS_W+5)'(col_r);

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.load_out) begin
      out_valid_nxt = 1'b1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      out_data_r.row_pos  <= row_ext[4:0];
      out_data_r.col_pos  <= col_ext[4:0];
      out_data_r.heading  <= dir_r;
      out_data_r.pen_down <= pen_r;
      out_data_r.row_bits <= bits_r;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

`ifndef SYNTHESIS
  a_step_has_count: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.step |-> cnt_r != 6'd0)
    else $error("step issued with no distance left");

  a_load_when_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load_out |-> status.out_free)
    else $error("result loaded over an untaken result");

  a_cap_after_issue: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.cap_row |-> $past(cmd.accept))
    else $error("row captured without a read issued the cycle before");

  a_no_write_at_accept: assert property (@(posedge clk) disable iff (!rst_n)
    wp_r |-> !cmd.accept)
    else $error("grid write still pending when a new item starts");
`endif

endmodule

// File: rtl/turtle_grid_plotter_top.sv
// top level of the turtle grid plotter
`timescale 1ns / 1ps

// Turtle on a GRID_SIZE x GRID_SIZE bitmap. One item in gives exactly one
// item out showing the turtle after the command. Pen up/down, turns and
// unused op codes go straight to the result; read row first waits for the
// registered grid read; forward walks one cell per cycle through the
// separate read and write ports of the grid memory with a read-modify-write
// pipeline and a bypass for back to back marks on the same row. Input is
// taken only when the previous item is finished; a finished result waits
// in the output register, and the next item is accepted while it waits.
// Grid rows carry one valid flop each, so the grid is all zero right after
// reset with no clearing pass.

module turtle_grid_plotter_top #(
  parameter int GRID_SIZE = 32
) (
  input  logic               clk,
  input  logic               rst_n,
  // command items
  input  logic               in_valid,
  output logic               in_stall,
  input  tgp_pkg::in_item_t  in_data,
  // result items
  output logic               out_valid,
  input  logic               out_stall,
  output tgp_pkg::out_item_t out_data
);

  tgp_pkg::cmd_t    cmd;
  tgp_pkg::status_t status;

  // sequencer: accept, walk, read, hand off
  tgp_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_data  (in_data),
    .in_stall (in_stall),
    .status   (status),
    .cmd      (cmd)
  );

  // turtle state, grid memory and output register
  tgp_datapath #(
    .GRID_SIZE (GRID_SIZE)
  ) u_datapath (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_data   (in_data),
    .cmd       (cmd),
    .status    (status),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule

// File: tb/sv/tb_turtle_grid_plotter_top.sv
// testbench for the turtle grid plotter: random and directed commands, scoreboard check
`timescale 1ns / 1ps

module tb_turtle_grid_plotter_top;

  localparam int GRID_SIZE = 32;
  localparam int RANDOM_ITEMS = 1400;
  // long receiver hold-off, long enough to fill the block and stall its input
  localparam int HOLD_CYCLES = 400;
  // tail wait, so this covers anything still in flight
  localparam int TAIL_CYCLES = 100;
  localparam int WATCHDOG_LIMIT = 5000;
  localparam int MAX_REPORTS = 10;

  // op codes the block has no name for, they must leave the turtle alone
  localparam logic [2:0] OP_SPARE_6 = 3'd6;
  localparam logic [2:0] OP_SPARE_7 = 3'd7;

  // receiver stall patterns
  localparam int RX_FREE = 0;
  localparam int RX_LIGHT = 1;
  localparam int RX_HEAVY = 2;
  localparam int RX_PERIODIC = 3;

  // tracks the turtle and its bitmap, and holds the results still owed
  class plot_tracker;
    logic [63:0] marks [64];
    int unsigned row;
    int unsigned col;
    logic [1:0] heading;
    logic pen;
    tgp_pkg::out_item_t owed_q[$];
    int errors;

    function new();
      foreach (marks[r]) marks[r] = '0;
      row = 0;
      col = 0;
      heading = tgp_pkg::HEAD_EAST;
      pen = 1'b0;
      errors = 0;
    endfunction

    function int pending();
      return owed_q.size();
    endfunction

    // apply one accepted command and queue the result it must give
    function void note_command(tgp_pkg::in_item_t cmd);
      tgp_pkg::out_item_t want;
      logic [31:0] bits;
      bits = '0;
      case (cmd.op)
        tgp_pkg::OP_PEN_UP:     pen = 1'b0;
        tgp_pkg::OP_PEN_DOWN:   pen = 1'b1;
        tgp_pkg::OP_TURN_RIGHT: heading = heading + 2'd1;
        tgp_pkg::OP_TURN_LEFT:  heading = heading - 2'd1;
        tgp_pkg::OP_FORWARD: begin
          for (int i = 0; i < cmd.distance; i++) begin
            case (heading)
              tgp_pkg::HEAD_EAST:  if (col + 1 < GRID_SIZE) col++;
              tgp_pkg::HEAD_SOUTH: if (row + 1 < GRID_SIZE) row++;
              tgp_pkg::HEAD_WEST:  if (col > 0) col--;
              default:             if (row > 0) row--;
            endcase
            // only the cell after each step is marked, so the starting cell only when held at the edge
            if (pen) marks[row][col] = 1'b1;
          end
        end
        tgp_pkg::OP_READ_ROW: begin
          if (cmd.row_select < GRID_SIZE) bits = marks[cmd.row_select][31:0];
        end
        default: ;
      endcase
      want.row_pos = row[4:0];
      want.col_pos = col[4:0];
      want.heading = heading;
      want.pen_down = pen;
      want.row_bits = bits;
      owed_q.push_back(want);
    endfunction

    function void check_result(tgp_pkg::out_item_t got);
      tgp_pkg::out_item_t want;
      if (owed_q.size() == 0) begin
        errors++;
        if (errors <= MAX_REPORTS)
          $display("unexpected result: row %0d col %0d head %0d pen %0d bits %h",
                   got.row_pos, got.col_pos, got.heading, got.pen_down, got.row_bits);
        return;
      end
      want = owed_q.pop_front();
      if (got.row_pos !== want.row_pos || got.col_pos !== want.col_pos ||
          got.heading !== want.heading || got.pen_down !== want.pen_down ||
          got.row_bits !== want.row_bits) begin
        errors++;
        if (errors <= MAX_REPORTS) begin
          $display("mismatch: want row %0d col %0d head %0d pen %0d bits %h",
                   want.row_pos, want.col_pos, want.heading, want.pen_down, want.row_bits);
          $display("          got  row %0d col %0d head %0d pen %0d bits %h",
                   got.row_pos, got.col_pos, got.heading, got.pen_down, got.row_bits);
        end
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  tgp_pkg::in_item_t in_data = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  tgp_pkg::out_item_t out_data;

  // main process asks the receiver for one long hold-off through this flag
  logic hold_req = 1'b0;

  plot_tracker tracker = new();

  turtle_grid_plotter_top #(
    .GRID_SIZE(GRID_SIZE)
  ) dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data (out_data)
  );

  // 10 ns clock
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // every accepted command feeds the predictor, every accepted result is checked
  always @(posedge clk) begin
    if (rst_n && in_valid && !in_stall) tracker.note_command(in_data);
    if (rst_n && out_valid && !out_stall) tracker.check_result(out_data);
  end

  // receiver: one long hold-off on request, otherwise a randomly chosen
  // pattern of no stall, light, heavy or periodic stalling
  int hold_left = 0;
  logic hold_taken = 1'b0;
  int rx_mode = RX_FREE;
  int rx_cycle = 0;

  always @(posedge clk) begin
    if (hold_req && !hold_taken) begin
      hold_taken <= 1'b1;
      hold_left <= HOLD_CYCLES;
      out_stall <= 1'b1;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      out_stall <= 1'b1;
    end else begin
      rx_cycle <= rx_cycle + 1;
      if (rx_cycle % 97 == 0) rx_mode <= $urandom_range(RX_FREE, RX_PERIODIC);
      case (rx_mode)
        RX_FREE:  out_stall <= 1'b0;
        RX_LIGHT: out_stall <= ($urandom_range(0, 3) == 0);
        RX_HEAVY: out_stall <= ($urandom_range(0, 3) != 0);
        default:  out_stall <= (rx_cycle % 5) < 2;
      endcase
    end
  end

  // watchdog: too long without any item moving on either side
  int idle_cycles = 0;

  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  // offer one command and hold it until the block takes it
  task automatic send_cmd(input tgp_pkg::in_item_t cmd);
    in_valid <= 1'b1;
    in_data <= cmd;
    do @(posedge clk); while (in_stall);
  endtask

  // stop offering and wait until every owed result has come back
  task automatic wait_all_done();
    in_valid <= 1'b0;
    do @(negedge clk); while (tracker.pending() != 0);
    @(posedge clk);
  endtask

  function automatic tgp_pkg::in_item_t make_cmd(logic [2:0] op, logic [5:0] steps,
                                                 logic [4:0] rsel);
    tgp_pkg::in_item_t cmd;
    cmd.op = op;
    cmd.distance = steps;
    cmd.row_select = rsel;
    return cmd;
  endfunction

  // random command: pen down and forward most often so the bitmap fills up,
  // short moves most of the time, a few long ones to hit the edges
  function automatic tgp_pkg::in_item_t random_cmd();
    tgp_pkg::in_item_t cmd;
    int pick;
    int span;
    pick = $urandom_range(0, 99);
    span = $urandom_range(0, 99);
    cmd.distance = 6'($urandom_range(0, 63));
    cmd.row_select = 5'($urandom_range(0, 31));
    if (pick < 10) cmd.op = tgp_pkg::OP_PEN_UP;
    else if (pick < 28) cmd.op = tgp_pkg::OP_PEN_DOWN;
    else if (pick < 40) cmd.op = tgp_pkg::OP_TURN_RIGHT;
    else if (pick < 52) cmd.op = tgp_pkg::OP_TURN_LEFT;
    else if (pick < 82) begin
      cmd.op = tgp_pkg::OP_FORWARD;
      if (span < 80) cmd.distance = 6'($urandom_range(0, 8));
      else if (span < 95) cmd.distance = 6'($urandom_range(9, 31));
      else cmd.distance = 6'($urandom_range(32, 63));
    end else if (pick < 97) cmd.op = tgp_pkg::OP_READ_ROW;
    else cmd.op = ($urandom_range(0, 1) == 0) ? OP_SPARE_6 : OP_SPARE_7;
    return cmd;
  endfunction

  tgp_pkg::in_item_t directed_q[$];
  int burst_left;
  int gap;

  initial begin
    // reset held, then released once
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: empty grid, pen up moves, zero distance, edge clamping on
    // all four sides, every turn, spare op codes and extreme field values
    directed_q.push_back(make_cmd(tgp_pkg::OP_READ_ROW, 6'd0, 5'd0));
    directed_q.push_back(make_cmd(tgp_pkg::OP_FORWARD, 6'd0, 5'd31));
    directed_q.push_back(make_cmd(tgp_pkg::OP_FORWARD, 6'd5, 5'd0));
    directed_q.push_back(make_cmd(tgp_pkg::OP_READ_ROW, 6'd63, 5'd0));
    // pen down must not mark the current cell
    directed_q.push_back(make_cmd(tgp_pkg::OP_PEN_DOWN, 6'd0, 5'd0));
    directed_q.push_back(make_cmd(tgp_pkg::OP_READ_ROW, 6'd0, 5'd0));
    directed_q.push_back(make_cmd(tgp_pkg::OP_FORWARD, 6'd63, 5'd0));
    directed_q.push_back(make_cmd(tgp_pkg::OP_READ_ROW, 6'd0, 5'd0));
    directed_q.push_back(make_cmd(tgp_pkg::OP_TURN_RIGHT, 6'd0, 5'd0));
    directed_q.push_back(make_cmd(tgp_pkg::OP_FORWARD, 6'd3, 5'd0));
    directed_q.push_back(make_cmd(tgp_pkg::OP_TURN_LEFT, 6'd0, 5'd0));
    // already on the east edge, marks the same cell again
    directed_q.push_back(make_cmd(tgp_pkg::OP_FORWARD, 6'd2, 5'd0));
    directed_q.push_back(make_cmd(tgp_pkg::OP_READ_ROW, 6'd0, 5'd3));
    directed_q.push_back(make_cmd(tgp_pkg::OP_TURN_RIGHT, 6'd0, 5'd0));
    directed_q.push_back(make_cmd(tgp_pkg::OP_TURN_RIGHT, 6'd0, 5'd0));
    directed_q.push_back(make_cmd(tgp_pkg::OP_FORWARD, 6'd63, 5'd0));
    directed_q.push_back(make_cmd(tgp_pkg::OP_TURN_RIGHT, 6'd0, 5'd0));
    directed_q.push_back(make_cmd(tgp_pkg::OP_FORWARD, 6'd63, 5'd0));
    directed_q.push_back(make_cmd(tgp_pkg::OP_TURN_LEFT, 6'd0, 5'd0));
    directed_q.push_back(make_cmd(tgp_pkg::OP_TURN_LEFT, 6'd0, 5'd0));
    directed_q.push_back(make_cmd(tgp_pkg::OP_FORWARD, 6'd63, 5'd0));
    directed_q.push_back(make_cmd(OP_SPARE_6, 6'd63, 5'd31));
    directed_q.push_back(make_cmd(OP_SPARE_7, 6'd42, 5'd21));
    directed_q.push_back(make_cmd(tgp_pkg::OP_READ_ROW, 6'd0, 5'd31));
    directed_q.push_back(make_cmd(tgp_pkg::OP_PEN_UP, 6'd63, 5'd31));
    foreach (directed_q[i]) send_cmd(directed_q[i]);
    wait_all_done();

    // random part in bursts with random gaps in between
    burst_left = 0;
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      // long receiver hold-off while commands keep coming
      if (n == 400) hold_req <= 1'b1;
      // sender pause until the block has caught up completely
      if (n == 800) wait_all_done();
      if (burst_left == 0) begin
        burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(60, 150)
                                                 : $urandom_range(1, 24);
        gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
        if (gap > 0) begin
          in_valid <= 1'b0;
          repeat (gap) @(posedge clk);
        end
      end
      burst_left--;
      send_cmd(random_cmd());
    end

    wait_all_done();
    // let anything stray come out before the verdict
    repeat (TAIL_CYCLES) @(posedge clk);
    @(negedge clk);
    if (tracker.errors == 0 && tracker.pending() == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

// File: files.f
rtl/tgp_pkg.sv
rtl/tgp_ram.sv
rtl/tgp_ctrl.sv
rtl/tgp_datapath.sv
rtl/turtle_grid_plotter_top.sv
tb/sv/tb_turtle_grid_plotter_top.sv
